// ===== rtl/ctt_pkg.sv =====
// Shared token codes, character codes and the token record for the text tokenizer.
package ctt_pkg;

	localparam int TokWidth = 16;

	// Token type codes
	localparam logic [3:0] TT_END     = 4'd0;
	localparam logic [3:0] TT_LPAREN  = 4'd1;
	localparam logic [3:0] TT_RPAREN  = 4'd2;
	localparam logic [3:0] TT_COLON   = 4'd3;
	localparam logic [3:0] TT_SEMI    = 4'd4;
	localparam logic [3:0] TT_STAR    = 4'd5;
	localparam logic [3:0] TT_LBRACK  = 4'd6;
	localparam logic [3:0] TT_RBRACK  = 4'd7;
	localparam logic [3:0] TT_LBRACE  = 4'd8;
	localparam logic [3:0] TT_RBRACE  = 4'd9;
	localparam logic [3:0] TT_HASH    = 4'd10;
	localparam logic [3:0] TT_STRING  = 4'd11;
	localparam logic [3:0] TT_IDENT   = 4'd12;
	localparam logic [3:0] TT_UNKNOWN = 4'd13;

	// Character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef struct packed {
		logic [3:0]          ttype;
		logic [TokWidth-1:0] offset;
		logic [TokWidth-1:0] length;
		logic                last;
	} token_t;

endpackage

// ===== rtl/ctt_lexer.sv =====
// Mode machine of the tokenizer: takes one byte per beat and yields up to two tokens.
module ctt_lexer #(
	parameter int OFFSET_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic [7:0]         char_in,
	output ctt_pkg::token_t    tok0,
	output ctt_pkg::token_t    tok1,
	output logic [1:0]         tok_count
);

	typedef enum logic [2:0] {
		M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_BLOCK_STAR, M_STRING, M_STRING_ESC, M_IDENT
	} mode_t;

	localparam logic [OFFSET_BITS-1:0] PosMax = '1;
	localparam logic [OFFSET_BITS-1:0] LenOne = OFFSET_BITS'(1);

	mode_t                  mode_q, mode_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic [OFFSET_BITS-1:0] start_q, start_d;

	logic [OFFSET_BITS-1:0] pos_inc, span;
	logic                   is_space, is_alpha, is_tail;

	// Idle-byte handling, always computed and used where a mode falls back to idle
	mode_t                  idle_mode;
	logic                   idle_set_start;
	logic [OFFSET_BITS-1:0] idle_start;
	logic                   idle_emit, idle_end;
	logic [3:0]             idle_type;

	logic                   use_idle;
	logic                   pre_emit;
	logic [3:0]             pre_type;
	logic [OFFSET_BITS-1:0] pre_off, pre_len;
	ctt_pkg::token_t        pre_tok, idle_tok;

	function automatic logic [ctt_pkg::TokWidth-1:0] clamp(input logic [OFFSET_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'h0000_FFFF) ? '1 : w[ctt_pkg::TokWidth-1:0];
	endfunction

	always_comb begin
		pos_inc  = (pos_q == PosMax) ? pos_q : pos_q + LenOne;
		span     = (pos_q >= start_q) ? pos_q - start_q : '0;
		is_space = char_in == ctt_pkg::CH_SPACE || char_in == ctt_pkg::CH_TAB
			|| char_in == ctt_pkg::CH_VT || char_in == ctt_pkg::CH_FF
			|| char_in == ctt_pkg::CH_LF || char_in == ctt_pkg::CH_CR;
		is_alpha = (char_in >= 8'h61 && char_in <= 8'h7A) || (char_in >= 8'h41 && char_in <= 8'h5A);
		is_tail  = is_alpha || (char_in >= 8'h30 && char_in <= 8'h39)
			|| char_in == ctt_pkg::CH_UNDER;
	end

	always_comb begin
		idle_mode      = M_IDLE;
		idle_set_start = 1'b0;
		idle_start     = pos_q;
		idle_emit      = 1'b0;
		idle_end       = 1'b0;
		idle_type      = ctt_pkg::TT_UNKNOWN;
		if (is_space) begin
			idle_emit = 1'b0;
		end else if (char_in == ctt_pkg::CH_NUL) begin
			idle_emit = 1'b1;
			idle_end  = 1'b1;
			idle_type = ctt_pkg::TT_END;
		end else if (char_in == ctt_pkg::CH_SLASH) begin
			idle_mode      = M_SLASH;
			idle_set_start = 1'b1;
		end else if (char_in == ctt_pkg::CH_QUOTE) begin
			idle_mode      = M_STRING;
			idle_set_start = 1'b1;
			idle_start     = pos_inc;
		end else if (is_alpha) begin
			idle_mode      = M_IDENT;
			idle_set_start = 1'b1;
		end else begin
			idle_emit = 1'b1;
			unique case (char_in)
				ctt_pkg::CH_LPAREN: idle_type = ctt_pkg::TT_LPAREN;
				ctt_pkg::CH_RPAREN: idle_type = ctt_pkg::TT_RPAREN;
				ctt_pkg::CH_COLON:  idle_type = ctt_pkg::TT_COLON;
				ctt_pkg::CH_SEMI:   idle_type = ctt_pkg::TT_SEMI;
				ctt_pkg::CH_STAR:   idle_type = ctt_pkg::TT_STAR;
				ctt_pkg::CH_LBRACK: idle_type = ctt_pkg::TT_LBRACK;
				ctt_pkg::CH_RBRACK: idle_type = ctt_pkg::TT_RBRACK;
				ctt_pkg::CH_LBRACE: idle_type = ctt_pkg::TT_LBRACE;
				ctt_pkg::CH_RBRACE: idle_type = ctt_pkg::TT_RBRACE;
				ctt_pkg::CH_HASH:   idle_type = ctt_pkg::TT_HASH;
				default:            idle_type = ctt_pkg::TT_UNKNOWN;
			endcase
		end
	end

	always_comb begin
		use_idle = 1'b0;
		pre_emit = 1'b0;
		pre_type = ctt_pkg::TT_STRING;
		pre_off  = start_q;
		pre_len  = span;
		mode_d   = mode_q;
		unique case (mode_q)
			M_IDENT: begin
				if (!is_tail) begin
					pre_emit = 1'b1;
					pre_type = ctt_pkg::TT_IDENT;
					use_idle = 1'b1;
				end
			end
			M_SLASH: begin
				if (char_in == ctt_pkg::CH_SLASH) begin
					mode_d = M_LINE;
				end else if (char_in == ctt_pkg::CH_STAR) begin
					mode_d = M_BLOCK;
				end else begin
					pre_emit = 1'b1;
					pre_type = ctt_pkg::TT_UNKNOWN;
					pre_len  = LenOne;
					use_idle = 1'b1;
				end
			end
			M_LINE: begin
				if (char_in == ctt_pkg::CH_NUL) use_idle = 1'b1;
				else if (char_in == ctt_pkg::CH_LF || char_in == ctt_pkg::CH_CR) mode_d = M_IDLE;
			end
			M_BLOCK: begin
				if (char_in == ctt_pkg::CH_NUL) use_idle = 1'b1;
				else if (char_in == ctt_pkg::CH_STAR) mode_d = M_BLOCK_STAR;
			end
			M_BLOCK_STAR: begin
				if (char_in == ctt_pkg::CH_NUL) use_idle = 1'b1;
				else if (char_in == ctt_pkg::CH_SLASH) mode_d = M_IDLE;
				else if (char_in != ctt_pkg::CH_STAR) mode_d = M_BLOCK;
			end
			M_STRING: begin
				if (char_in == ctt_pkg::CH_NUL) begin
					pre_emit = 1'b1;
					use_idle = 1'b1;
				end else if (char_in == ctt_pkg::CH_QUOTE) begin
					pre_emit = 1'b1;
					mode_d   = M_IDLE;
				end else if (char_in == ctt_pkg::CH_BSLASH) begin
					mode_d = M_STRING_ESC;
				end
			end
			M_STRING_ESC: begin
				if (char_in == ctt_pkg::CH_NUL) begin
					pre_emit = 1'b1;
					use_idle = 1'b1;
				end else begin
					mode_d = M_STRING;
				end
			end
			default: use_idle = 1'b1;
		endcase

		start_d = start_q;
		if (use_idle) begin
			mode_d = idle_mode;
			if (idle_set_start) start_d = idle_start;
		end

		// End of stream restarts the offset count
		if (use_idle && idle_end) begin
			mode_d = M_IDLE;
			pos_d  = '0;
		end else begin
			pos_d = pos_inc;
		end
	end

	always_comb begin
		pre_tok.ttype   = pre_type;
		pre_tok.offset  = clamp(pre_off);
		pre_tok.length  = clamp(pre_len);
		pre_tok.last    = !(use_idle && idle_emit);
		idle_tok.ttype  = idle_type;
		idle_tok.offset = clamp(pos_q);
		idle_tok.length = clamp(LenOne);
		idle_tok.last   = 1'b1;
		tok_count = 2'(pre_emit) + 2'(use_idle && idle_emit);
		tok0 = pre_emit ? pre_tok : idle_tok;
		tok1 = idle_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pos_q   <= '0;
			start_q <= '0;
		end else if (fire) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			start_q <= start_d;
		end
	end

endmodule

// ===== rtl/ctt_token_fifo.sv =====
// Four-entry token queue that takes up to two tokens and gives one per beat.
module ctt_token_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      push_count,
	input  ctt_pkg::token_t push0,
	input  ctt_pkg::token_t push1,
	output logic            has_room,
	output logic            pop_valid,
	input  logic            pop_ready,
	output ctt_pkg::token_t head
);

	localparam int Depth = 4;

	ctt_pkg::token_t                 mem_q [Depth];
	logic [$clog2(Depth)-1:0]        wr_q, rd_q;
	logic [$clog2(Depth):0]          count_q;
	logic                            pop;

	assign pop_valid = count_q != '0;
	assign pop       = pop_valid && pop_ready;
	assign has_room  = count_q <= ($clog2(Depth)+1)'(Depth - 2);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) mem_q[wr_q] <= push0;
		if (push_count == 2'd2) mem_q[wr_q + 1'b1] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + $clog2(Depth)'(push_count);
			rd_q    <= rd_q + $clog2(Depth)'(pop);
			count_q <= count_q + ($clog2(Depth)+1)'(push_count) - ($clog2(Depth)+1)'(pop);
		end
	end

endmodule

// ===== rtl/c_like_text_tokenizer_unit.sv =====
// Top level of the C-like text tokenizer: byte channel in, token channel out.
//
// Usage:
//   Byte channel (char_valid/char_ready, char_in) carries one text byte per
//   beat; a zero byte marks end of stream and restarts offsets at 0.
//   Token channel (token_valid/token_ready) carries one token per beat:
//   token_type, token_offset, token_length and last_of_run, which flags the
//   final token caused by a given byte. A byte causes zero, one or two tokens
//   (an identifier, lone slash or string closed by the next byte comes first).
//   Tokens are written into the token queue at their byte beat, in order.
//   Throughput: one byte per cycle while the token side keeps up; the byte
//   side is held off only when the four-entry token queue could not take two
//   more tokens, so the queue sets the limit when bytes yield two tokens.
//   Reset: arst_n clears the mode machine (idle between tokens), the byte
//   offset and the queue; no token is pending after reset.
//   Stall: when token_ready is low the head token holds, the queue fills and
//   char_ready drops once two free slots are no longer guaranteed.
//   Offsets and lengths saturate at 2^OFFSET_BITS-1 and are clamped to 16 bits.
module c_like_text_tokenizer_unit #(
	parameter int OFFSET_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_ready,
	input  logic [7:0]  char_in,
	output logic        token_valid,
	input  logic        token_ready,
	output logic [3:0]  token_type,
	output logic [15:0] token_offset,
	output logic [15:0] token_length,
	output logic        last_of_run
);

	logic            fire;
	logic            has_room;
	logic [1:0]      tok_count;
	logic [1:0]      push_count;
	ctt_pkg::token_t tok0, tok1, head;

	// Accept a byte only when the queue can take the worst case of two tokens
	assign char_ready = has_room;
	assign fire       = char_valid && char_ready;
	assign push_count = fire ? tok_count : 2'd0;

	ctt_lexer #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_lexer (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.char_in   (char_in),
		.tok0      (tok0),
		.tok1      (tok1),
		.tok_count (tok_count)
	);

	ctt_token_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (push_count),
		.push0      (tok0),
		.push1      (tok1),
		.has_room   (has_room),
		.pop_valid  (token_valid),
		.pop_ready  (token_ready),
		.head       (head)
	);

	// Drive the token beat from the queue head
	assign token_type   = head.ttype;
	assign token_offset = head.offset;
	assign token_length = head.length;
	assign last_of_run  = head.last;

endmodule
